// ===== rtl/core/recursive_gaussian_column_blur_macros.svh =====
// Assertion macros shared by the recursive Gaussian column blur RTL.
// No dependencies; included by the files that carry assertions.
`ifndef RECURSIVE_GAUSSIAN_COLUMN_BLUR_MACROS_SVH
`define RECURSIVE_GAUSSIAN_COLUMN_BLUR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGCB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgcb assertion failed");

// Next-cycle implication, checked outside reset.
`define RGCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgcb assertion failed");

`endif

// ===== rtl/core/rgcb_pkg.sv =====
// Package for the recursive Gaussian column blur: widths, codes and types.
// No dependencies; used by every module of the block.
package rgcb_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STORE_BITS  = 48;
  localparam int COEF_BITS   = 28;
  localparam int COEF_FRAC   = 24;
  localparam int DATA_FRAC   = STORE_BITS - SAMPLE_BITS;
  localparam int MAX_ROWS    = 64;
  localparam int MIN_ROWS    = 3;
  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = 9;
  localparam int SIZE_W      = 10;
  localparam int LEN_W       = 7;
  localparam int PAD_W       = 9;
  localparam int PASS_W      = 9;
  localparam int HALF_W      = STORE_BITS / 2 + 1;
  localparam int PROD_W      = HALF_W + COEF_BITS;
  localparam int ACC_W       = 56;
  localparam int DIV_W       = STORE_BITS + 1;
  localparam int DIV_CNT_W   = 6;
  localparam int STEP_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int TAP_SEL_W   = 2;

  // Row sequencer steps: read, eight multiplies, drain, write back.
  localparam logic [STEP_W-1:0] STEP_FIRST_OP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_OP  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_WRITE    = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ZERO  = 3'd0,
    CFG_COEF_ONE   = 3'd1,
    CFG_COEF_TWO   = 3'd2,
    CFG_COEF_THREE = 3'd3,
    CFG_COL_LEN    = 3'd4,
    CFG_PAD_LEN    = 3'd5,
    CFG_PASS_CNT   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PAD,
    S_FILT,
    S_NORM_RD,
    S_NORM_ST,
    S_NORM_DIV,
    S_NORM_OUT
  } state_t;

endpackage

// ===== rtl/core/rgcb_tap_mac.sv =====
// Shared tap multiplier and accumulator for the recursive filter passes.
// Depends on rgcb_pkg.
module rgcb_tap_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  clr,
  input  logic                                  op_vld,
  input  logic                                  op_hi,
  input  logic signed [rgcb_pkg::STORE_BITS-1:0] val,
  input  logic signed [rgcb_pkg::COEF_BITS-1:0]  coef,
  output logic signed [rgcb_pkg::ACC_W-1:0]      acc
);

  logic signed [rgcb_pkg::HALF_W-1:0] opa;
  logic signed [rgcb_pkg::PROD_W-1:0] prod_r;
  logic                               pvld_r;
  logic                               phi_r;
  logic signed [rgcb_pkg::ACC_W-1:0]  prod_ext;
  logic signed [rgcb_pkg::ACC_W-1:0]  term;
  logic signed [rgcb_pkg::ACC_W-1:0]  acc_r;
  logic signed [rgcb_pkg::ACC_W-1:0]  acc_nxt;

  // The value is split in halves so one 25 x 28 multiplier serves the tap.
  assign opa = op_hi ? {val[rgcb_pkg::STORE_BITS-1],
                        val[rgcb_pkg::STORE_BITS-1:rgcb_pkg::STORE_BITS/2]}
                     : {1'b0, val[rgcb_pkg::STORE_BITS/2-1:0]};

  // Product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= op_vld;
    end
    prod_r <= opa * coef;
    phi_r  <= op_hi;
  end

  // The high half adds as is; the low half is rounded, ties upward.
  always_comb begin
    prod_ext = rgcb_pkg::ACC_W'(prod_r);
    if (phi_r) begin
      term = prod_ext;
    end else begin
      term = (prod_ext + (rgcb_pkg::ACC_W'(1) <<< (rgcb_pkg::COEF_FRAC - 1)))
             >>> rgcb_pkg::COEF_FRAC;
    end
    if (clr) begin
      acc_nxt = '0;
    end else if (pvld_r) begin
      acc_nxt = acc_r + term;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/rgcb_div.sv =====
// Bit-serial restoring divider with round-half-away and sample saturation.
// Depends on rgcb_pkg.
module rgcb_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [rgcb_pkg::STORE_BITS-1:0]  num,
  input  logic signed [rgcb_pkg::STORE_BITS-1:0]  den,
  output logic                                   done,
  output logic signed [rgcb_pkg::SAMPLE_BITS-1:0] quo,
  output logic                                   clip
);

  localparam logic [rgcb_pkg::SAMPLE_BITS-1:0] SMAX =
    {1'b0, {(rgcb_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic [rgcb_pkg::SAMPLE_BITS-1:0] SMIN =
    {1'b1, {(rgcb_pkg::SAMPLE_BITS-1){1'b0}}};

  logic                                busy_r;
  logic                                done_r;
  logic [rgcb_pkg::DIV_CNT_W-1:0]      cnt_r;
  logic [rgcb_pkg::STORE_BITS-1:0]     rem_r;
  logic [rgcb_pkg::STORE_BITS-1:0]     dvs_r;
  logic [rgcb_pkg::DIV_W-1:0]          dnum_r;
  logic [rgcb_pkg::DIV_W-1:0]          q_r;
  logic                                neg_r;
  logic                                zero_r;
  logic                                nnz_r;
  logic                                nsign_r;
  logic [rgcb_pkg::STORE_BITS-1:0]     num_abs;
  logic [rgcb_pkg::STORE_BITS-1:0]     den_abs;
  logic [rgcb_pkg::DIV_W-1:0]          n_tot;
  logic [rgcb_pkg::DIV_W-1:0]          trial;
  logic                                ge;
  logic [rgcb_pkg::DIV_W-1:0]          rem_nxt;
  logic [rgcb_pkg::DIV_W-1:0]          smax_w;

  // Operand magnitudes and the rounding offset of half the divisor.
  always_comb begin
    num_abs = num[rgcb_pkg::STORE_BITS-1] ? (~num + 1'b1) : num;
    den_abs = den[rgcb_pkg::STORE_BITS-1] ? (~den + 1'b1) : den;
    n_tot   = {1'b0, num_abs} + {2'b0, den_abs[rgcb_pkg::STORE_BITS-1:1]};
    trial   = {rem_r, dnum_r[rgcb_pkg::DIV_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= rgcb_pkg::DIV_CNT_W'(rgcb_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rgcb_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rem_r   <= '0;
      dvs_r   <= den_abs;
      dnum_r  <= n_tot;
      q_r     <= '0;
      neg_r   <= num[rgcb_pkg::STORE_BITS-1] ^ den[rgcb_pkg::STORE_BITS-1];
      zero_r  <= (den == '0);
      nnz_r   <= (num != '0);
      nsign_r <= num[rgcb_pkg::STORE_BITS-1];
    end else if (busy_r) begin
      rem_r  <= rem_nxt[rgcb_pkg::STORE_BITS-1:0];
      dnum_r <= {dnum_r[rgcb_pkg::DIV_W-2:0], 1'b0};
      q_r    <= {q_r[rgcb_pkg::DIV_W-2:0], ge};
    end
  end

  // Sign, saturation and the zero-divisor case.
  always_comb begin
    smax_w = rgcb_pkg::DIV_W'(SMAX);
    if (zero_r) begin
      clip = nnz_r;
      quo  = nnz_r ? (nsign_r ? SMIN : SMAX) : '0;
    end else if (neg_r) begin
      clip = q_r > (smax_w + 1'b1);
      quo  = clip ? SMIN : (~q_r[rgcb_pkg::SAMPLE_BITS-1:0] + 1'b1);
    end else begin
      clip = q_r > smax_w;
      quo  = clip ? SMAX : q_r[rgcb_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/core/recursive_gaussian_column_blur.sv =====
// Recursive Gaussian column blur: loads a column, runs the passes on a shared
// tap MAC over two 512-entry stores, then normalizes each row serially.
// Sequence: each accepted sample loads one row, the pad rows are zero filled, then the MAC runs
// 4*pass_count sweeps over min(len+pad, 512) rows, then each output row goes through the divider.
// Throughput: one column at a time; the input stalls until the last row is registered.
// Reset (synchronous, active low) restores register defaults and clears the row count.
`include "recursive_gaussian_column_blur_macros.svh"
module recursive_gaussian_column_blur (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rgcb_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rgcb_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_last_of_column,
  output logic                                   out_clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rgcb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rgcb_pkg::COEF_BITS-1:0]          cfg_data
);

  localparam int SB = rgcb_pkg::STORE_BITS;

  rgcb_pkg::state_t state_r, state_nxt;

  logic signed [rgcb_pkg::COEF_BITS-1:0] cfg_coef_r [0:3];
  logic [rgcb_pkg::LEN_W-1:0]            cfg_len_r;
  logic [rgcb_pkg::PAD_W-1:0]            cfg_pad_r;
  logic [rgcb_pkg::PASS_W-1:0]           cfg_pass_r;

  logic signed [rgcb_pkg::COEF_BITS-1:0] wcoef_r [0:3];
  logic [rgcb_pkg::LEN_W-1:0]            len_r, len_nxt;
  logic [rgcb_pkg::SIZE_W-1:0]           size_r, size_nxt;
  logic [rgcb_pkg::PASS_W-1:0]           passes_r, passes_nxt;
  logic [rgcb_pkg::LEN_W-1:0]            rows_loaded_r, rows_loaded_nxt;
  logic [rgcb_pkg::ADDR_W-1:0]           x_r, x_nxt;
  logic [rgcb_pkg::STEP_W-1:0]           step_r, step_nxt;
  logic                                  sel_r, sel_nxt;
  logic                                  dir_r, dir_nxt;
  logic                                  latch_work;

  logic signed [SB-1:0] hist_r [1:3];
  logic signed [SB-1:0] col_mem [0:rgcb_pkg::STORE_DEPTH-1];
  logic signed [SB-1:0] att_mem [0:rgcb_pkg::STORE_DEPTH-1];
  logic signed [SB-1:0] col_rd_r, att_rd_r;
  logic                 col_we, att_we;
  logic [rgcb_pkg::ADDR_W-1:0] wr_addr;
  logic signed [SB-1:0] col_wd, att_wd;

  logic [rgcb_pkg::LEN_W-1:0]  eff_len;
  logic [rgcb_pkg::LEN_W-1:0]  pos;
  logic [rgcb_pkg::SIZE_W-1:0] size_sum, size_cap;
  logic                        in_acc;
  logic                        col_done;

  logic                                  mac_clr, mac_vld, mac_hi;
  logic [2:0]                            op_idx;
  logic [rgcb_pkg::TAP_SEL_W-1:0]        tap;
  logic signed [SB-1:0]                  mac_val;
  logic signed [rgcb_pkg::ACC_W-1:0]     acc;
  logic signed [SB-1:0]                  acc_sat;
  logic [rgcb_pkg::ADDR_W-1:0]           last_x;
  logic                                  sweep_end;

  logic                                   div_start, div_done, div_clip;
  logic signed [rgcb_pkg::SAMPLE_BITS-1:0] div_q;
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [rgcb_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic                                   out_last_r, out_clip_r, out_load;

  // Configuration registers; the port never waits.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_coef_r[0] <= rgcb_pkg::COEF_BITS'(1) <<< rgcb_pkg::COEF_FRAC;
      cfg_coef_r[1] <= '0;
      cfg_coef_r[2] <= '0;
      cfg_coef_r[3] <= '0;
      cfg_len_r     <= rgcb_pkg::LEN_W'(rgcb_pkg::MAX_ROWS);
      cfg_pad_r     <= '0;
      cfg_pass_r    <= rgcb_pkg::PASS_W'(1);
    end else if (cfg_valid) begin
      unique case (rgcb_pkg::cfg_idx_t'(cfg_index))
        rgcb_pkg::CFG_COEF_ZERO:  cfg_coef_r[0] <= cfg_data;
        rgcb_pkg::CFG_COEF_ONE:   cfg_coef_r[1] <= cfg_data;
        rgcb_pkg::CFG_COEF_TWO:   cfg_coef_r[2] <= cfg_data;
        rgcb_pkg::CFG_COEF_THREE: cfg_coef_r[3] <= cfg_data;
        rgcb_pkg::CFG_COL_LEN:    cfg_len_r  <= cfg_data[rgcb_pkg::LEN_W-1:0];
        rgcb_pkg::CFG_PAD_LEN:    cfg_pad_r  <= cfg_data[rgcb_pkg::PAD_W-1:0];
        rgcb_pkg::CFG_PASS_CNT:   cfg_pass_r <= cfg_data[rgcb_pkg::PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length, load position and padded size.
  always_comb begin
    if (cfg_len_r < rgcb_pkg::LEN_W'(rgcb_pkg::MIN_ROWS)) begin
      eff_len = rgcb_pkg::LEN_W'(rgcb_pkg::MIN_ROWS);
    end else if (cfg_len_r > rgcb_pkg::LEN_W'(rgcb_pkg::MAX_ROWS)) begin
      eff_len = rgcb_pkg::LEN_W'(rgcb_pkg::MAX_ROWS);
    end else begin
      eff_len = cfg_len_r;
    end
    pos      = (rows_loaded_r < eff_len) ? rows_loaded_r : (eff_len - 1'b1);
    size_sum = rgcb_pkg::SIZE_W'(eff_len) + rgcb_pkg::SIZE_W'(cfg_pad_r);
    size_cap = (size_sum > rgcb_pkg::SIZE_W'(rgcb_pkg::STORE_DEPTH))
             ? rgcb_pkg::SIZE_W'(rgcb_pkg::STORE_DEPTH) : size_sum;
    in_acc   = in_valid && !in_stall;
    col_done = in_acc && (pos == eff_len - 1'b1);
  end

  assign in_stall = (state_r != rgcb_pkg::S_LOAD);

  // Operand selection for the shared MAC: cur value, then three history taps.
  always_comb begin
    op_idx  = 3'(step_r - rgcb_pkg::STEP_FIRST_OP);
    tap     = op_idx[2:1];
    mac_hi  = op_idx[0];
    mac_vld = (state_r == rgcb_pkg::S_FILT) && (step_r >= rgcb_pkg::STEP_FIRST_OP)
              && (step_r <= rgcb_pkg::STEP_LAST_OP);
    mac_clr = (state_r == rgcb_pkg::S_FILT) && (step_r == '0);
    case (tap)
      2'd0:    mac_val = sel_r ? att_rd_r : col_rd_r;
      2'd1:    mac_val = hist_r[1];
      2'd2:    mac_val = hist_r[2];
      default: mac_val = hist_r[3];
    endcase
  end

  rgcb_tap_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (mac_clr),
    .op_vld (mac_vld),
    .op_hi  (mac_hi),
    .val    (mac_val),
    .coef   (wcoef_r[tap]),
    .acc    (acc)
  );

  // Saturate the tap sum to the store width.
  always_comb begin
    if (acc > $signed(rgcb_pkg::ACC_W'({1'b0, {(SB-1){1'b1}}}))) begin
      acc_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (acc < -(rgcb_pkg::ACC_W'(1) <<< (SB-1))) begin
      acc_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      acc_sat = acc[SB-1:0];
    end
  end

  assign div_start = (state_r == rgcb_pkg::S_NORM_ST);

  rgcb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (col_rd_r),
    .den   (att_rd_r),
    .done  (div_done),
    .quo   (div_q),
    .clip  (div_clip)
  );

  // Sequencer: next state, counters and store write port.
  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    step_nxt        = step_r;
    sel_nxt         = sel_r;
    dir_nxt         = dir_r;
    passes_nxt      = passes_r;
    rows_loaded_nxt = rows_loaded_r;
    len_nxt         = len_r;
    size_nxt        = size_r;
    latch_work      = 1'b0;
    col_we          = 1'b0;
    att_we          = 1'b0;
    wr_addr         = x_r;
    col_wd          = '0;
    att_wd          = '0;
    out_load        = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    last_x          = rgcb_pkg::ADDR_W'(size_r - 1'b1);
    sweep_end       = dir_r ? (x_r == '0) : (x_r == last_x);
    unique case (state_r)
      rgcb_pkg::S_LOAD: begin
        if (in_acc) begin
          col_we          = 1'b1;
          att_we          = 1'b1;
          wr_addr         = rgcb_pkg::ADDR_W'(pos);
          col_wd          = {in_sample_in, {rgcb_pkg::DATA_FRAC{1'b0}}};
          att_wd          = SB'(1) <<< rgcb_pkg::DATA_FRAC;
          rows_loaded_nxt = pos + 1'b1;
        end
        if (col_done) begin
          rows_loaded_nxt = '0;
          latch_work      = 1'b1;
          len_nxt         = eff_len;
          size_nxt        = size_cap;
          passes_nxt      = cfg_pass_r;
          step_nxt        = '0;
          sel_nxt         = 1'b0;
          dir_nxt         = 1'b0;
          if (size_cap > rgcb_pkg::SIZE_W'(eff_len)) begin
            state_nxt = rgcb_pkg::S_PAD;
            x_nxt     = rgcb_pkg::ADDR_W'(eff_len);
          end else begin
            x_nxt     = '0;
            state_nxt = (cfg_pass_r == '0) ? rgcb_pkg::S_NORM_RD : rgcb_pkg::S_FILT;
          end
        end
      end
      rgcb_pkg::S_PAD: begin
        col_we = 1'b1;
        att_we = 1'b1;
        if (rgcb_pkg::SIZE_W'(x_r) + 1'b1 == size_r) begin
          x_nxt     = '0;
          state_nxt = (passes_r == '0) ? rgcb_pkg::S_NORM_RD : rgcb_pkg::S_FILT;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      rgcb_pkg::S_FILT: begin
        if (step_r == rgcb_pkg::STEP_WRITE) begin
          col_we   = !sel_r;
          att_we   = sel_r;
          col_wd   = acc_sat;
          att_wd   = acc_sat;
          step_nxt = '0;
          if (!sweep_end) begin
            x_nxt = dir_r ? (x_r - 1'b1) : (x_r + 1'b1);
          end else if (!dir_r) begin
            dir_nxt = 1'b1;
          end else begin
            dir_nxt = 1'b0;
            x_nxt   = '0;
            if (!sel_r) begin
              sel_nxt = 1'b1;
            end else begin
              sel_nxt    = 1'b0;
              passes_nxt = passes_r - 1'b1;
              if (passes_r == rgcb_pkg::PASS_W'(1)) begin
                state_nxt = rgcb_pkg::S_NORM_RD;
              end
            end
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      rgcb_pkg::S_NORM_RD: begin
        state_nxt = rgcb_pkg::S_NORM_ST;
      end
      rgcb_pkg::S_NORM_ST: begin
        state_nxt = rgcb_pkg::S_NORM_DIV;
      end
      rgcb_pkg::S_NORM_DIV: begin
        if (div_done) begin
          state_nxt = rgcb_pkg::S_NORM_OUT;
        end
      end
      rgcb_pkg::S_NORM_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (rgcb_pkg::LEN_W'(x_r) == len_r - 1'b1) begin
            state_nxt = rgcb_pkg::S_LOAD;
            x_nxt     = '0;
          end else begin
            x_nxt     = x_r + 1'b1;
            state_nxt = rgcb_pkg::S_NORM_RD;
          end
        end
      end
      default: state_nxt = rgcb_pkg::S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rgcb_pkg::S_LOAD;
      rows_loaded_r <= '0;
      out_valid_r   <= 1'b0;
      x_r           <= '0;
      step_r        <= '0;
      sel_r         <= 1'b0;
      dir_r         <= 1'b0;
      passes_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      rows_loaded_r <= rows_loaded_nxt;
      out_valid_r   <= out_valid_nxt;
      x_r           <= x_nxt;
      step_r        <= step_nxt;
      sel_r         <= sel_nxt;
      dir_r         <= dir_nxt;
      passes_r      <= passes_nxt;
    end
  end

  // Column work registers, filter history and output payload.
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    size_r <= size_nxt;
    if (latch_work) begin
      wcoef_r[0] <= cfg_coef_r[0];
      wcoef_r[1] <= cfg_coef_r[1];
      wcoef_r[2] <= cfg_coef_r[2];
      wcoef_r[3] <= cfg_coef_r[3];
    end
    if (state_r != rgcb_pkg::S_FILT) begin
      hist_r[1] <= '0;
      hist_r[2] <= '0;
      hist_r[3] <= '0;
    end else if (step_r == rgcb_pkg::STEP_WRITE) begin
      hist_r[1] <= sweep_end ? '0 : acc_sat;
      hist_r[2] <= sweep_end ? '0 : hist_r[1];
      hist_r[3] <= sweep_end ? '0 : hist_r[2];
    end
    if (out_load) begin
      out_sample_r <= div_q;
      out_clip_r   <= div_clip;
      out_last_r   <= (rgcb_pkg::LEN_W'(x_r) == len_r - 1'b1);
    end
  end

  // Column and attenuation stores: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[wr_addr] <= col_wd;
    end
    if (att_we) begin
      att_mem[wr_addr] <= att_wd;
    end
    col_rd_r <= col_mem[x_r];
    att_rd_r <= att_mem[x_r];
  end

  assign out_valid          = out_valid_r;
  assign out_sample_out     = out_sample_r;
  assign out_last_of_column = out_last_r;
  assign out_clipped        = out_clip_r;

  // Checks on the sequencer.
  `RGCB_ASSERT_NEXT(a_out_from_norm, !out_valid_r && out_valid_nxt, $past(state_r == rgcb_pkg::S_NORM_OUT))
  `RGCB_ASSERT_NOW(a_step_bound, state_r == rgcb_pkg::S_FILT, step_r <= rgcb_pkg::STEP_WRITE)
  `RGCB_ASSERT_NOW(a_div_done_state, div_done, state_r == rgcb_pkg::S_NORM_DIV)
  `RGCB_ASSERT_NOW(a_filt_addr, state_r == rgcb_pkg::S_FILT, rgcb_pkg::SIZE_W'(x_r) < size_r)

endmodule

// ===== tb/column_blur_checker.sv =====
// Checker for the recursive Gaussian column blur: watches all three channels,
// predicts every output row and compares it. Depends on rgcb_pkg only.
module column_blur_checker
  import rgcb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          out_last_of_column,
  input  logic                          out_clipped,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_data,
  output int                            error_count,
  output int                            pending,
  output int                            rows_checked,
  output int                            clipped_rows
);

  typedef longint store_t [STORE_DEPTH];

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          clip;
  } blur_row_t;

  // Shadow of the configuration registers and the loading state.
  logic [COEF_BITS-1:0] coef [4];
  logic [LEN_W-1:0]     len_reg;
  logic [PAD_W-1:0]     pad_reg;
  logic [PASS_W-1:0]    pass_reg;
  int                   rows_loaded;
  store_t               col_store;
  store_t               att_store;
  blur_row_t            expected_rows [$];

  initial begin
    error_count  = 0;
    pending      = 0;
    rows_checked = 0;
    clipped_rows = 0;
  end

  // One coefficient tap, rounded to nearest with ties toward plus infinity.
  function automatic longint tap(longint v, longint c);
    longint vh, vl;
    vh = v >>> COEF_FRAC;
    vl = v - (vh <<< COEF_FRAC);
    return vh * c + ((vl * c + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC);
  endfunction

  function automatic longint sat_store(longint s);
    longint hi;
    hi = (64'sd1 <<< (STORE_BITS - 1)) - 1;
    if (s > hi) return hi;
    if (s < -hi - 1) return -hi - 1;
    return s;
  endfunction

  // Causal sweep followed by an anti-causal sweep, zero initial conditions.
  function automatic void sweep_pair(inout store_t b, input int n, input longint c [4]);
    longint acc;
    for (int x = 0; x < n; x++) begin
      acc = tap(b[x], c[0]);
      for (int k = 1; k <= 3; k++)
        if (x - k >= 0) acc += tap(b[x - k], c[k]);
      b[x] = sat_store(acc);
    end
    for (int x = n - 1; x >= 0; x--) begin
      acc = tap(b[x], c[0]);
      for (int k = 1; k <= 3; k++)
        if (x + k < n) acc += tap(b[x + k], c[k]);
      b[x] = sat_store(acc);
    end
  endfunction

  // Load one sample; on the last row filter the column and queue its rows.
  task automatic load_sample(logic signed [SAMPLE_BITS-1:0] s);
    int        len, pos, size;
    longint    c [4];
    longint    num, den, n, d, q, smax;
    blur_row_t row;
    len = (len_reg < MIN_ROWS) ? MIN_ROWS : ((len_reg > MAX_ROWS) ? MAX_ROWS : len_reg);
    pos = (rows_loaded < len) ? rows_loaded : len - 1;
    col_store[pos] = longint'(s) <<< DATA_FRAC;
    rows_loaded = pos + 1;
    if (rows_loaded < len) return;
    rows_loaded = 0;
    size = len + pad_reg;
    if (size > STORE_DEPTH) size = STORE_DEPTH;
    for (int x = len; x < size; x++) col_store[x] = 0;
    for (int x = 0; x < size; x++) att_store[x] = (x < len) ? (64'sd1 <<< DATA_FRAC) : 0;
    for (int p = 0; p < 4; p++) c[p] = longint'($signed(coef[p]));
    for (int p = 0; p < pass_reg; p++) begin
      sweep_pair(col_store, size, c);
      sweep_pair(att_store, size, c);
    end
    smax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    for (int x = 0; x < len; x++) begin
      num = col_store[x];
      den = att_store[x];
      row.clip = 1'b0;
      if (den == 0) begin
        q = (num > 0) ? smax : ((num < 0) ? -smax - 1 : 0);
        row.clip = (num != 0);
      end else begin
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n + d / 2) / d;
        if ((num < 0) != (den < 0)) q = -q;
        if (q > smax) begin
          q = smax;
          row.clip = 1'b1;
        end
        if (q < -smax - 1) begin
          q = -smax - 1;
          row.clip = 1'b1;
        end
      end
      row.sample = q[SAMPLE_BITS-1:0];
      row.last   = (x == len - 1);
      expected_rows.push_back(row);
    end
  endtask

  // Track register writes, accepted samples and delivered rows.
  always @(posedge clk) begin
    blur_row_t want;
    if (!rst_n) begin
      coef[0]     = 28'd16777216;
      coef[1]     = '0;
      coef[2]     = '0;
      coef[3]     = '0;
      len_reg     = 7'd64;
      pad_reg     = '0;
      pass_reg    = 9'd1;
      rows_loaded = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COEF_ZERO:  coef[0] = cfg_data;
          CFG_COEF_ONE:   coef[1] = cfg_data;
          CFG_COEF_TWO:   coef[2] = cfg_data;
          CFG_COEF_THREE: coef[3] = cfg_data;
          CFG_COL_LEN:    len_reg = cfg_data[LEN_W-1:0];
          CFG_PAD_LEN:    pad_reg = cfg_data[PAD_W-1:0];
          CFG_PASS_CNT:   pass_reg = cfg_data[PASS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) load_sample(in_sample_in);
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected output row: sample_out %0d", out_sample_out);
          error_count++;
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (out_clipped) clipped_rows++;
          if (out_sample_out !== want.sample) begin
            $error("sample_out expected %0d actual %0d", want.sample, out_sample_out);
            error_count++;
          end
          if (out_last_of_column !== want.last) begin
            $error("last_of_column expected %0d actual %0d", want.last, out_last_of_column);
            error_count++;
          end
          if (out_clipped !== want.clip) begin
            $error("clipped expected %0d actual %0d", want.clip, out_clipped);
            error_count++;
          end
        end
      end
    end
    pending = expected_rows.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the column blur testbench: clock, reset, stimulus and verdict.
// Depends on rgcb_pkg, the block and column_blur_checker.
module tb;
  import rgcb_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          out_last_of_column;
  logic                          out_clipped;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [COEF_BITS-1:0]          cfg_data;
  int                            error_count, pending, rows_checked, clipped_rows;
  int                            samples_sent, phases, cycles;
  logic                          calm;

  recursive_gaussian_column_blur dut (.*);

  column_blur_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stalls at random outside the calm stretch.
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 15);

  function automatic logic [COEF_BITS-1:0] q24(real r);
    return COEF_BITS'($rtoi(r * 16777216.0));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // One register write transaction; leaves the channel idle.
  task automatic put_reg(cfg_idx_t idx, logic [COEF_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One sample transaction with an optional gap in front of it.
  task automatic send(logic signed [SAMPLE_BITS-1:0] s);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  // Stop sending and wait until every predicted row has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic set_all(logic [COEF_BITS-1:0] c0, logic [COEF_BITS-1:0] c1,
                         logic [COEF_BITS-1:0] c2, logic [COEF_BITS-1:0] c3,
                         int len, int pad, int passes);
    put_reg(CFG_COEF_ZERO, c0);
    put_reg(CFG_COEF_ONE, c1);
    put_reg(CFG_COEF_TWO, c2);
    put_reg(CFG_COEF_THREE, c3);
    put_reg(CFG_COL_LEN, COEF_BITS'(len));
    put_reg(CFG_PAD_LEN, COEF_BITS'(pad));
    put_reg(CFG_PASS_CNT, COEF_BITS'(passes));
    phases++;
  endtask

  // Random coefficient set: smooth low-pass shapes half of the time.
  task automatic random_coefs();
    real c1, c2, c3;
    int  mode;
    mode = $urandom_range(3);
    if (mode < 2) begin
      c1 = 0.5 + $urandom_range(1000) / 1000.0;
      c2 = -($urandom_range(600) / 1000.0);
      c3 = ($urandom_range(200) / 1000.0) - 0.1;
      put_reg(CFG_COEF_ZERO, q24(1.0 - c1 - c2 - c3));
      put_reg(CFG_COEF_ONE, q24(c1));
      put_reg(CFG_COEF_TWO, q24(c2));
      put_reg(CFG_COEF_THREE, q24(c3));
    end else begin
      for (int k = 0; k < 4; k++)
        put_reg(cfg_idx_t'(k), (mode == 2) ? COEF_BITS'($urandom)
                                           : COEF_BITS'($urandom_range(33554431) - 16777216));
    end
  endtask

  initial begin
    int len, pad, passes, count;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    calm         = 1'b0;
    samples_sent = 0;
    phases       = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity filter on the sample extremes.
    set_all(q24(1.0), '0, '0, '0, 3, 0, 1);
    send(24'sh7fffff);
    send(24'sh800000);
    send('0);
    settle();

    // No passes at all: output equals input.
    put_reg(CFG_PASS_CNT, '0);
    for (int i = 0; i < 3; i++) send(pick_sample());
    settle();

    // Length below the minimum and a zero gain, so the attenuation is zero.
    set_all('0, '0, '0, '0, 0, 2, 1);
    for (int i = 0; i < 3; i++) send(pick_sample());
    settle();

    // Column length shrunk while a column is partly loaded.
    set_all(q24(0.4), q24(0.9), q24(-0.4), q24(0.1), 6, 5, 2);
    for (int i = 0; i < 4; i++) send(pick_sample());
    settle();
    put_reg(CFG_COL_LEN, COEF_BITS'(4));
    send(pick_sample());
    settle();

    // Coefficient extremes with the padded size capped by the store.
    set_all(28'h7ffffff, 28'h8000000, 28'h7ffffff, 28'h8000000, 3, 511, 1);
    for (int i = 0; i < 3; i++) send(pick_sample());
    settle();

    // Largest pass count on a short column.
    set_all(q24(0.3), q24(1.1), q24(-0.5), q24(0.1), 3, 0, 511);
    for (int i = 0; i < 3; i++) send(pick_sample());
    settle();

    // Random columns, each under a new setting.
    while (samples_sent < 140) begin
      calm = (phases >= 9 && phases < 13);
      if ($urandom_range(7) != 0) random_coefs();
      len    = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(12, 3);
      pad    = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(24);
      passes = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
      if (pad > 100) passes = $urandom_range(2, 1);
      if ($urandom_range(11) == 0) begin
        len    = 3;
        pad    = $urandom_range(4);
        passes = $urandom_range(300, 100);
      end
      put_reg(CFG_COL_LEN, COEF_BITS'(len));
      put_reg(CFG_PAD_LEN, COEF_BITS'(pad));
      put_reg(CFG_PASS_CNT, COEF_BITS'(passes));
      phases++;
      count = (len < MIN_ROWS) ? MIN_ROWS : ((len > MAX_ROWS) ? MAX_ROWS : len);
      if ($urandom_range(5) == 0 && count > 3) begin
        // Part of a column, then a new length, which may end it at once.
        for (int i = 0; i < count / 2; i++) send(pick_sample());
        settle();
        len = $urandom_range(count, 3);
        put_reg(CFG_COL_LEN, COEF_BITS'(len));
        count = (len <= count / 2) ? 1 : len - count / 2;
      end
      for (int i = 0; i < count; i++) send(pick_sample());
      settle();
    end
    calm = 1'b0;

    settle();
    $display("Drove %0d samples over %0d register settings.", samples_sent, phases);
    $display("Compared %0d output rows, %0d of them saturated.", rows_checked, clipped_rows);
    if (error_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
